### rtl/core/rcg_pkg.sv
// Shared types, constants and helper functions for the color-grid pattern core.
// No dependencies; imported by every module of the core.
package rcg_pkg;

  localparam int RES_W   = 13;  // resolution and rectangle size width
  localparam int OFF_W   = 26;  // frame buffer byte offset width
  localparam int COLOR_W = 32;  // packed color width
  localparam int CIDX_W  = 3;   // configuration register index width
  localparam int CDAT_W  = 32;  // configuration write word width

  localparam logic [15:0] CH5_MASK = 16'h001f;
  localparam logic [15:0] CH6_MASK = 16'h003f;
  localparam logic [15:0] CH8_MASK = 16'h00ff;

  typedef enum logic [2:0] {
    MODE_INDEXED = 3'd0,
    MODE_1555    = 3'd1,
    MODE_565     = 3'd2,
    MODE_888     = 3'd3,
    MODE_8888    = 3'd4
  } color_mode_t;

  typedef enum logic [CIDX_W-1:0] {
    CFG_COLOR_MODE    = 3'd0,
    CFG_PIXEL_BITS    = 3'd1,
    CFG_CHANNEL_SIZES = 3'd2,
    CFG_RECT_COUNT    = 3'd3,
    CFG_FIRST_COLOR   = 3'd4,
    CFG_COLOR_STEP    = 3'd5,
    CFG_HORIZ_RES     = 3'd6,
    CFG_VERT_RES      = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic [2:0]         color_mode;
    logic [5:0]         pixel_bits;
    logic [11:0]        channel_sizes;
    logic [7:0]         rect_count;
    logic [COLOR_W-1:0] first_color;
    logic [7:0]         color_step;
    logic [RES_W-1:0]   horiz_res;
    logic [RES_W-1:0]   vert_res;
  } cfg_t;

  // Grid geometry derived from the registers.
  typedef struct packed {
    logic [RES_W-1:0] rect_wid;
    logic [RES_W-1:0] rect_hgt;
    logic             grid_ok;
  } geom_t;

  // One restoring division step: returns {quotient bit, new remainder}.
  function automatic logic [RES_W:0] div_step(input logic [RES_W-1:0] rem,
                                              input logic dbit,
                                              input logic [RES_W-1:0] dvs);
    logic [RES_W:0] t;
    logic [RES_W:0] d;
    t = {rem, dbit};
    d = t - {1'b0, dvs};
    if (t >= {1'b0, dvs}) begin
      return {1'b1, d[RES_W-1:0]};
    end
    return {1'b0, t[RES_W-1:0]};
  endfunction

  // Low mask of sz ones, sz up to 15.
  function automatic logic [15:0] low_mask16(input logic [3:0] sz);
    logic [16:0] m;
    m = (17'd1 << sz) - 17'd1;
    return m[15:0];
  endfunction

endpackage

### rtl/core/rcg_cfg_div.sv
// Multi-cycle divider that derives rectangle width and height from the registers.
// Depends on rcg_pkg.
module rcg_cfg_div (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    kick,
  input  rcg_pkg::cfg_t           cfg,
  output logic                    busy,
  output rcg_pkg::geom_t          geom
);
  import rcg_pkg::*;

  localparam int CNT_W = $clog2(RES_W);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_LOAD = 3'b010,
    ST_RUN  = 3'b100
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [RES_W-1:0] dvd_h_r, dvd_h_nxt, dvd_v_r, dvd_v_nxt;
  logic [RES_W-1:0] rem_h_r, rem_h_nxt, rem_v_r, rem_v_nxt;
  logic [RES_W-1:0] quo_h_r, quo_h_nxt, quo_v_r, quo_v_nxt;
  geom_t            geom_r, geom_nxt;
  logic [RES_W:0]   st_h, st_v;
  logic [RES_W-1:0] dvs;

  assign dvs  = RES_W'(cfg.rect_count);
  assign st_h = div_step(rem_h_r, dvd_h_r[RES_W-1], dvs);
  assign st_v = div_step(rem_v_r, dvd_v_r[RES_W-1], dvs);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    dvd_h_nxt = dvd_h_r;
    dvd_v_nxt = dvd_v_r;
    rem_h_nxt = rem_h_r;
    rem_v_nxt = rem_v_r;
    quo_h_nxt = quo_h_r;
    quo_v_nxt = quo_v_r;
    geom_nxt  = geom_r;
    case (state_r)
      ST_IDLE: begin
        if (kick) begin
          state_nxt = ST_LOAD;
        end
      end
      ST_LOAD: begin
        dvd_h_nxt = cfg.horiz_res;
        dvd_v_nxt = cfg.vert_res;
        rem_h_nxt = '0;
        rem_v_nxt = '0;
        quo_h_nxt = '0;
        quo_v_nxt = '0;
        cnt_nxt   = '0;
        state_nxt = ST_RUN;
      end
      ST_RUN: begin
        dvd_h_nxt = dvd_h_r << 1;
        dvd_v_nxt = dvd_v_r << 1;
        rem_h_nxt = st_h[RES_W-1:0];
        rem_v_nxt = st_v[RES_W-1:0];
        quo_h_nxt = {quo_h_r[RES_W-2:0], st_h[RES_W]};
        quo_v_nxt = {quo_v_r[RES_W-2:0], st_v[RES_W]};
        cnt_nxt   = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(RES_W - 1)) begin
          geom_nxt.rect_wid = quo_h_nxt;
          geom_nxt.rect_hgt = quo_v_nxt;
          geom_nxt.grid_ok  = (cfg.rect_count != '0) && (quo_h_nxt != '0) &&
                              (quo_v_nxt != '0);
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= ST_IDLE;
      geom_r.rect_wid <= RES_W'(1024);
      geom_r.rect_hgt <= RES_W'(768);
      geom_r.grid_ok  <= 1'b1;
    end else begin
      state_r <= state_nxt;
      geom_r  <= geom_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r   <= cnt_nxt;
    dvd_h_r <= dvd_h_nxt;
    dvd_v_r <= dvd_v_nxt;
    rem_h_r <= rem_h_nxt;
    rem_v_r <= rem_v_nxt;
    quo_h_r <= quo_h_nxt;
    quo_v_r <= quo_v_nxt;
  end

  assign busy = (state_r != ST_IDLE);
  assign geom = geom_r;

endmodule

### rtl/core/rcg_pix_div.sv
// Pipelined restoring divider: rectangle column and row of a pixel, one bit per stage.
// Depends on rcg_pkg.
module rcg_pix_div #(
  parameter int N = 12
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_vld,
  input  logic [N-1:0]               in_x,
  input  logic [N-1:0]               in_y,
  input  logic [rcg_pkg::RES_W-1:0]  wid,
  input  logic [rcg_pkg::RES_W-1:0]  hgt,
  output logic                       out_vld,
  output logic [N-1:0]               out_x,
  output logic [N-1:0]               out_y,
  output logic [N-1:0]               out_col,
  output logic [N-1:0]               out_row
);
  import rcg_pkg::*;

  logic             vld_r [N];
  logic [N-1:0]     x_r   [N];
  logic [N-1:0]     y_r   [N];
  logic [N-1:0]     qx_r  [N];
  logic [N-1:0]     qy_r  [N];
  logic [RES_W-1:0] rx_r  [N];
  logic [RES_W-1:0] ry_r  [N];

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic             pv;
    logic [N-1:0]     px, py, pqx, pqy;
    logic [RES_W-1:0] prx, pry;
    logic [RES_W:0]   sx, sy;

    if (k == 0) begin : g_first
      assign pv  = in_vld;
      assign px  = in_x;
      assign py  = in_y;
      assign pqx = '0;
      assign pqy = '0;
      assign prx = '0;
      assign pry = '0;
    end else begin : g_next
      assign pv  = vld_r[k-1];
      assign px  = x_r[k-1];
      assign py  = y_r[k-1];
      assign pqx = qx_r[k-1];
      assign pqy = qy_r[k-1];
      assign prx = rx_r[k-1];
      assign pry = ry_r[k-1];
    end

    // bit N-1-k of the dividend is brought down here
    assign sx = div_step(prx, px[N-1-k], wid);
    assign sy = div_step(pry, py[N-1-k], hgt);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else begin
        vld_r[k] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      x_r[k]  <= px;
      y_r[k]  <= py;
      qx_r[k] <= {pqx[N-2:0], sx[RES_W]};
      qy_r[k] <= {pqy[N-2:0], sy[RES_W]};
      rx_r[k] <= sx[RES_W-1:0];
      ry_r[k] <= sy[RES_W-1:0];
    end
  end

  assign out_vld = vld_r[N-1];
  assign out_x   = x_r[N-1];
  assign out_y   = y_r[N-1];
  assign out_col = qx_r[N-1];
  assign out_row = qy_r[N-1];

endmodule

### rtl/core/rcg_color.sv
// Four-stage color, byte offset and byte count pipeline behind the divider.
// Depends on rcg_pkg.
module rcg_color #(
  parameter int N = 12
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  rcg_pkg::cfg_t                cfg,
  input  rcg_pkg::geom_t               geom,
  input  logic                         in_vld,
  input  logic [N-1:0]                 in_x,
  input  logic [N-1:0]                 in_y,
  input  logic [N-1:0]                 in_col,
  input  logic [N-1:0]                 in_row,
  output logic                         out_vld,
  output logic                         out_drawn,
  output logic [rcg_pkg::COLOR_W-1:0]  out_color,
  output logic [rcg_pkg::OFF_W-1:0]    out_offset,
  output logic [2:0]                   out_bytes
);
  import rcg_pkg::*;

  function automatic logic [15:0] chan(input logic [15:0] base,
                                       input logic [15:0] add,
                                       input logic [3:0] sz);
    return (base + add) & low_mask16(sz);
  endfunction

  // stage 1: range check and the independent products
  logic             c1_vld_r, c1_drawn_r;
  logic [7:0]       c1_c8_r;
  logic [15:0]      c1_rc_r, c1_cs_r, c1_rs_r;
  logic [OFF_W-1:0] c1_lin_r;
  // stage 2: sums, offset scaling
  logic             c2_vld_r, c2_drawn_r;
  logic [15:0]      c2_idx_r, c2_cs_r, c2_rs_r;
  logic [16:0]      c2_bs_r;
  logic [OFF_W-1:0] c2_off_r;
  // stage 3: index times step
  logic             c3_vld_r, c3_drawn_r;
  logic [23:0]      c3_prod_r;
  logic [15:0]      c3_cs_r, c3_rs_r;
  logic [16:0]      c3_bs_r;
  logic [OFF_W-1:0] c3_off_r;
  // stage 4: output word
  logic               c4_vld_r, c4_drawn_r;
  logic [COLOR_W-1:0] c4_color_r, c4_color_nxt;
  logic [OFF_W-1:0]   c4_off_r;
  logic [2:0]         c4_bytes_r;

  logic             drawn_nxt;
  logic [2:0]       bytes;
  logic [OFF_W-1:0] off_nxt;
  logic [COLOR_W-1:0] ind_mask;
  logic [32:0]      ind_m33;
  logic [3:0]       rsz, gsz, bsz;
  logic [15:0]      red, grn, blu;

  assign drawn_nxt = geom.grid_ok &&
                     (RES_W'(in_col) < RES_W'(cfg.rect_count)) &&
                     (RES_W'(in_row) < RES_W'(cfg.rect_count));

  // bytes per pixel: 15 bits packs in 2 bytes, else bits/8 held to 1..4
  always_comb begin
    if (cfg.pixel_bits == 6'd15) begin
      bytes = 3'd2;
    end else if (cfg.pixel_bits[5:3] == 3'd0) begin
      bytes = 3'd1;
    end else if (cfg.pixel_bits[5:3] > 3'd4) begin
      bytes = 3'd4;
    end else begin
      bytes = cfg.pixel_bits[5:3];
    end
  end

  always_comb begin
    case (bytes)
      3'd2:    off_nxt = c1_lin_r << 1;
      3'd3:    off_nxt = (c1_lin_r << 1) + c1_lin_r;
      3'd4:    off_nxt = c1_lin_r << 2;
      default: off_nxt = c1_lin_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c1_vld_r <= 1'b0;
      c2_vld_r <= 1'b0;
      c3_vld_r <= 1'b0;
      c4_vld_r <= 1'b0;
    end else begin
      c1_vld_r <= in_vld;
      c2_vld_r <= c1_vld_r;
      c3_vld_r <= c2_vld_r;
      c4_vld_r <= c3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    c1_drawn_r <= drawn_nxt;
    c1_c8_r    <= in_col[7:0];
    c1_rc_r    <= 16'(in_row[7:0]) * 16'(cfg.rect_count);
    c1_cs_r    <= 16'(in_col[7:0]) * 16'(cfg.color_step);
    c1_rs_r    <= 16'(in_row[7:0]) * 16'(cfg.color_step);
    c1_lin_r   <= OFF_W'(cfg.horiz_res) * OFF_W'(in_y) + OFF_W'(in_x);

    c2_drawn_r <= c1_drawn_r;
    c2_idx_r   <= c1_rc_r + 16'(c1_c8_r);
    c2_cs_r    <= c1_cs_r;
    c2_rs_r    <= c1_rs_r;
    c2_bs_r    <= 17'(c1_cs_r) + 17'(c1_rs_r);
    c2_off_r   <= off_nxt;

    c3_drawn_r <= c2_drawn_r;
    c3_prod_r  <= 24'(c2_idx_r) * 24'(cfg.color_step);
    c3_cs_r    <= c2_cs_r;
    c3_rs_r    <= c2_rs_r;
    c3_bs_r    <= c2_bs_r;
    c3_off_r   <= c2_off_r;

    c4_drawn_r <= c3_drawn_r;
    c4_color_r <= c4_color_nxt;
    c4_off_r   <= c3_off_r;
    c4_bytes_r <= bytes;
  end

  // stage 4 color
  assign ind_m33 = (33'd1 << cfg.pixel_bits) - 33'd1;
  assign ind_mask = (cfg.pixel_bits >= 6'd32) ? '1 : ind_m33[COLOR_W-1:0];
  assign rsz = cfg.channel_sizes[11:8];
  assign gsz = cfg.channel_sizes[7:4];
  assign bsz = cfg.channel_sizes[3:0];

  always_comb begin
    red = '0;
    grn = '0;
    blu = '0;
    c4_color_nxt = '0;
    case (cfg.color_mode)
      MODE_INDEXED: begin
        c4_color_nxt = (cfg.first_color + COLOR_W'(c3_prod_r)) & ind_mask;
      end
      MODE_1555: begin
        red = chan(16'(cfg.first_color >> 10) & CH5_MASK, c3_cs_r, rsz);
        grn = chan(16'(cfg.first_color >> 5) & CH5_MASK, c3_rs_r, gsz);
        blu = chan(16'(cfg.first_color) & CH5_MASK, c3_bs_r[15:0], bsz);
        c4_color_nxt = (32'(red) << 10) | (32'(grn) << 5) | 32'(blu);
      end
      MODE_565: begin
        red = chan(16'(cfg.first_color >> 11) & CH5_MASK, c3_cs_r, rsz);
        grn = chan(16'(cfg.first_color >> 5) & CH6_MASK, c3_rs_r, gsz);
        blu = chan(16'(cfg.first_color) & CH5_MASK, c3_bs_r[15:0], bsz);
        c4_color_nxt = (32'(red) << 11) | (32'(grn) << 5) | 32'(blu);
      end
      MODE_888, MODE_8888: begin
        red = chan(16'(cfg.first_color >> 16) & CH8_MASK, c3_cs_r, rsz);
        grn = chan(16'(cfg.first_color >> 8) & CH8_MASK, c3_rs_r, gsz);
        blu = chan(16'(cfg.first_color) & CH8_MASK, c3_bs_r[15:0], bsz);
        c4_color_nxt = (32'(red) << 16) | (32'(grn) << 8) | 32'(blu);
      end
      default: begin
        c4_color_nxt = '0;
      end
    endcase
    if (!c3_drawn_r) begin
      c4_color_nxt = '0;
    end
  end

  assign out_vld    = c4_vld_r;
  assign out_drawn  = c4_drawn_r;
  assign out_color  = c4_color_r;
  assign out_offset = c4_off_r;
  assign out_bytes  = c4_bytes_r;

endmodule

### rtl/core/rect_grid_color_pattern_core.sv
// Color-grid test pattern generator: top level with registers, divider and pipeline.
// Depends on rcg_pkg, rcg_cfg_div, rcg_pix_div and rcg_color.
//
// Takes one pixel word (x, y) per clock whenever busy is low and returns one
// result word per pixel on out_strobe for a single cycle; the receiver cannot
// stall, so results are never held back. The pixel path is fully pipelined: an
// input register, one restoring-division stage per coordinate bit that finds
// the rectangle column and row, then four stages for range check, products,
// color packing and byte offset. Sustained rate is one pixel per clock while
// busy is low. Each configuration write starts a shared sequential divider that
// derives rectangle width and height (resolution / rect_count, one bit a
// cycle); busy and ~cfg_ready stay high while it runs. Write configuration
// only when no pixel results are outstanding.
module rect_grid_color_pattern_core #(
  parameter int COORD_BITS = 12
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // pixel command
  input  logic                          start,
  output logic                          busy,
  input  logic [COORD_BITS-1:0]         in_pix_x,
  input  logic [COORD_BITS-1:0]         in_pix_y,
  // result word
  output logic                          out_strobe,
  output logic                          out_drawn,
  output logic [rcg_pkg::COLOR_W-1:0]   out_pixel_color,
  output logic [rcg_pkg::OFF_W-1:0]     out_byte_offset,
  output logic [2:0]                    out_byte_count,
  // configuration write
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [rcg_pkg::CIDX_W-1:0]    cfg_index,
  input  logic [rcg_pkg::CDAT_W-1:0]    cfg_wdata
);
  import rcg_pkg::*;

  localparam int LATENCY = COORD_BITS + 5;

  cfg_t  cfg_r, cfg_nxt;
  geom_t geom;
  logic  cfg_we;
  logic  div_busy;
  logic  in_accept;

  // input register
  logic                  s0_vld_r;
  logic [COORD_BITS-1:0] s0_x_r, s0_y_r;

  // divider output
  logic                  d_vld;
  logic [COORD_BITS-1:0] d_x, d_y, d_col, d_row;

  assign cfg_ready = !div_busy;
  assign cfg_we    = cfg_valid && cfg_ready;
  assign busy      = div_busy;
  assign in_accept = start && !busy;

  // configuration registers
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_COLOR_MODE:    cfg_nxt.color_mode    = cfg_wdata[2:0];
        CFG_PIXEL_BITS:    cfg_nxt.pixel_bits    = cfg_wdata[5:0];
        CFG_CHANNEL_SIZES: cfg_nxt.channel_sizes = cfg_wdata[11:0];
        CFG_RECT_COUNT:    cfg_nxt.rect_count    = cfg_wdata[7:0];
        CFG_FIRST_COLOR:   cfg_nxt.first_color   = cfg_wdata[COLOR_W-1:0];
        CFG_COLOR_STEP:    cfg_nxt.color_step    = cfg_wdata[7:0];
        CFG_HORIZ_RES:     cfg_nxt.horiz_res     = cfg_wdata[RES_W-1:0];
        CFG_VERT_RES:      cfg_nxt.vert_res      = cfg_wdata[RES_W-1:0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.color_mode    <= MODE_INDEXED;
      cfg_r.pixel_bits    <= 6'd8;
      cfg_r.channel_sizes <= 12'h555;
      cfg_r.rect_count    <= 8'd1;
      cfg_r.first_color   <= '0;
      cfg_r.color_step    <= 8'd1;
      cfg_r.horiz_res     <= RES_W'(1024);
      cfg_r.vert_res      <= RES_W'(768);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // rectangle size; reset values match the reset registers
  rcg_cfg_div u_cfg_div (
    .clk   (clk),
    .rst_n (rst_n),
    .kick  (cfg_we),
    .cfg   (cfg_r),
    .busy  (div_busy),
    .geom  (geom)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
    end else begin
      s0_vld_r <= in_accept;
    end
  end

  always_ff @(posedge clk) begin
    s0_x_r <= in_pix_x;
    s0_y_r <= in_pix_y;
  end

  rcg_pix_div #(
    .N (COORD_BITS)
  ) u_pix_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (s0_vld_r),
    .in_x    (s0_x_r),
    .in_y    (s0_y_r),
    .wid     (geom.rect_wid),
    .hgt     (geom.rect_hgt),
    .out_vld (d_vld),
    .out_x   (d_x),
    .out_y   (d_y),
    .out_col (d_col),
    .out_row (d_row)
  );

  rcg_color #(
    .N (COORD_BITS)
  ) u_color (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .geom       (geom),
    .in_vld     (d_vld),
    .in_x       (d_x),
    .in_y       (d_y),
    .in_col     (d_col),
    .in_row     (d_row),
    .out_vld    (out_strobe),
    .out_drawn  (out_drawn),
    .out_color  (out_pixel_color),
    .out_offset (out_byte_offset),
    .out_bytes  (out_byte_count)
  );

`ifndef SYNTHESIS
  // every result word comes from an accepted pixel, checked at the pipeline latency
  a_out_from_accept: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(in_accept, LATENCY))
    else $error("result word without matching pixel");

  // a config write blocks pixels while the rectangle size is rebuilt
  a_cfg_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> busy)
    else $error("pixel port open right after config write");

  // pixels off the grid carry no color
  a_undrawn_black: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_drawn) |-> (out_pixel_color == '0))
    else $error("undrawn pixel with nonzero color");
`endif

endmodule
